// ----- sv/assert_macros.svh -----
// Assertion macros used by the port-level checker of the button click detector.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- sv/bcd_pkg.sv -----
// Shared types, event codes and register indexes of the button click detector.
// Depends on nothing; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package bcd_pkg;

    localparam int TIME_W  = 32;
    localparam int CLICK_W = 7;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 3;

    localparam logic [CLICK_W-1:0] CLICK_SAT = 7'd127;

    // Event codes reported with each result.
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_PRESS      = 3'd1;
    localparam logic [2:0] EV_CLICK      = 3'd2;
    localparam logic [2:0] EV_DOUBLE     = 3'd3;
    localparam logic [2:0] EV_MULTI      = 3'd4;
    localparam logic [2:0] EV_LONG_START = 3'd5;
    localparam logic [2:0] EV_LONG_DURING = 3'd6;
    localparam logic [2:0] EV_LONG_STOP  = 3'd7;

    // Register indexes of the configuration port.
    localparam logic [INDEX_W-1:0] REG_ACTIVE_LOW  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_CLICK       = 3'd2;
    localparam logic [INDEX_W-1:0] REG_PRESS       = 3'd3;
    localparam logic [INDEX_W-1:0] REG_IDLE        = 3'd4;
    localparam logic [INDEX_W-1:0] REG_REPEAT      = 3'd5;
    localparam logic [INDEX_W-1:0] REG_MAX_CLICKS  = 3'd6;
    localparam logic [INDEX_W-1:0] REG_IDLE_ENABLE = 3'd7;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] now_ms;
    } bcd_item_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic               idle_event;
        logic [CLICK_W-1:0] click_count;
        logic               debounced_level;
    } bcd_result_t;

    typedef struct packed {
        logic               active_low;
        logic [10:0]        debounce_ms;
        logic [15:0]        click_ms;
        logic [15:0]        press_ms;
        logic [15:0]        idle_ms;
        logic [15:0]        repeat_interval_ms;
        logic [CLICK_W-1:0] max_clicks;
        logic               idle_enable;
    } bcd_cfg_t;

endpackage

// ----- sv/bcd_cfg.sv -----
// Configuration register file of the button click detector.
// Depends on bcd_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module bcd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bcd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]    cfg_data,
    output bcd_pkg::bcd_cfg_t            cfg
);
    import bcd_pkg::*;

    bcd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low         <= 1'b0;
            cfg_reg.debounce_ms        <= 11'd50;
            cfg_reg.click_ms           <= 16'd400;
            cfg_reg.press_ms           <= 16'd800;
            cfg_reg.idle_ms            <= 16'd1000;
            cfg_reg.repeat_interval_ms <= 16'd0;
            cfg_reg.max_clicks         <= 7'd1;
            cfg_reg.idle_enable        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_LOW:  cfg_reg.active_low         <= cfg_data[0];
                REG_DEBOUNCE:    cfg_reg.debounce_ms        <= cfg_data[10:0];
                REG_CLICK:       cfg_reg.click_ms           <= cfg_data;
                REG_PRESS:       cfg_reg.press_ms           <= cfg_data;
                REG_IDLE:        cfg_reg.idle_ms            <= cfg_data;
                REG_REPEAT:      cfg_reg.repeat_interval_ms <= cfg_data;
                REG_MAX_CLICKS:  cfg_reg.max_clicks         <= cfg_data[CLICK_W-1:0];
                REG_IDLE_ENABLE: cfg_reg.idle_enable        <= cfg_data[0];
                default:         cfg_reg.idle_enable        <= cfg_reg.idle_enable;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/bcd_debounce.sv -----
// Level debouncer of the button click detector, updated once per request.
// Depends on bcd_pkg for the timestamp width.
`timescale 1ns / 1ps

module bcd_debounce (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        pressed,
    input  logic [bcd_pkg::TIME_W-1:0]  now_ms,
    input  logic [10:0]                 debounce_ms,
    output logic                        stable_level
);
    import bcd_pkg::*;

    logic              last_sample_reg, last_sample_next;
    logic [TIME_W-1:0] last_change_reg, last_change_next;
    logic              stable_reg;
    logic              deb_neg;
    logic [11:0]       deb_mag;
    logic [TIME_W-1:0] since_change;
    logic              early;

    always_comb
    begin
        deb_neg = debounce_ms[10];
        // A negative setting debounces only the release, by its magnitude.
        deb_mag = deb_neg ? (12'h800 - {1'b0, debounce_ms}) : {1'b0, debounce_ms};
        since_change = now_ms - last_change_reg;
        early = (pressed && deb_neg) ? 1'b1 : stable_reg;

        last_sample_next = last_sample_reg;
        last_change_next = last_change_reg;
        stable_level     = early;
        if (last_sample_reg == pressed)
        begin
            if (since_change >= {{(TIME_W-12){1'b0}}, deb_mag})
            begin
                stable_level = pressed;
            end
        end
        else
        begin
            last_change_next = now_ms;
            last_sample_next = pressed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= 1'b0;
            last_change_reg <= '0;
            stable_reg      <= 1'b0;
        end
        else if (step)
        begin
            last_sample_reg <= last_sample_next;
            last_change_reg <= last_change_next;
            stable_reg      <= stable_level;
        end
    end

endmodule

// ----- sv/bcd_fsm.sv -----
// Click and long-press state machine of the button click detector.
// Depends on bcd_pkg for the event codes, the configuration and the result struct.
`timescale 1ns / 1ps

module bcd_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        stable_level,
    input  logic [bcd_pkg::TIME_W-1:0]  now_ms,
    input  bcd_pkg::bcd_cfg_t           cfg,
    output bcd_pkg::bcd_result_t        result
);
    import bcd_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT     = 6'b000001,
        ST_DOWN     = 6'b000010,
        ST_UP       = 6'b000100,
        ST_COUNT    = 6'b001000,
        ST_PRESS    = 6'b010000,
        ST_PRESSEND = 6'b100000
    } bcd_state_t;

    bcd_state_t         state_reg, state_next;
    logic [CLICK_W-1:0] clicks_reg, clicks_next;
    logic [TIME_W-1:0]  phase_reg, phase_next;
    logic               idle_rep_reg, idle_rep_next;
    logic [TIME_W-1:0]  repeat_reg, repeat_next;
    logic [TIME_W-1:0]  wait_ms;
    logic [TIME_W-1:0]  since_repeat;

    always_comb
    begin
        wait_ms      = now_ms - phase_reg;
        since_repeat = now_ms - repeat_reg;

        state_next    = state_reg;
        clicks_next   = clicks_reg;
        phase_next    = phase_reg;
        idle_rep_next = idle_rep_reg;
        repeat_next   = repeat_reg;

        result.event_code      = EV_NONE;
        result.idle_event      = 1'b0;
        result.click_count     = clicks_reg;
        result.debounced_level = stable_level;

        unique case (state_reg)
            ST_INIT:
            begin
                // Idle and press may both be reported on one sample.
                if (!idle_rep_reg && cfg.idle_enable
                    && (wait_ms > {16'd0, cfg.idle_ms}))
                begin
                    idle_rep_next     = 1'b1;
                    result.idle_event = 1'b1;
                end
                if (stable_level)
                begin
                    state_next        = ST_DOWN;
                    phase_next        = now_ms;
                    clicks_next       = '0;
                    result.event_code = EV_PRESS;
                end
                result.click_count = clicks_next;
            end
            ST_DOWN:
            begin
                if (!stable_level)
                begin
                    state_next = ST_UP;
                    phase_next = now_ms;
                end
                else if (wait_ms > {16'd0, cfg.press_ms})
                begin
                    state_next        = ST_PRESS;
                    result.event_code = EV_LONG_START;
                end
            end
            ST_UP:
            begin
                if (clicks_reg < CLICK_SAT)
                begin
                    clicks_next = clicks_reg + 7'd1;
                end
                state_next         = ST_COUNT;
                result.click_count = clicks_next;
            end
            ST_COUNT:
            begin
                if (stable_level)
                begin
                    state_next = ST_DOWN;
                    phase_next = now_ms;
                end
                else if ((wait_ms >= {16'd0, cfg.click_ms})
                         || (clicks_reg == cfg.max_clicks))
                begin
                    if (clicks_reg == 7'd1)
                        result.event_code = EV_CLICK;
                    else if (clicks_reg == 7'd2)
                        result.event_code = EV_DOUBLE;
                    else
                        result.event_code = EV_MULTI;
                    state_next    = ST_INIT;
                    clicks_next   = '0;
                    phase_next    = now_ms;
                    idle_rep_next = 1'b0;
                end
            end
            ST_PRESS:
            begin
                if (!stable_level)
                begin
                    state_next = ST_PRESSEND;
                end
                else if (since_repeat >= {16'd0, cfg.repeat_interval_ms})
                begin
                    result.event_code = EV_LONG_DURING;
                    repeat_next       = now_ms;
                end
            end
            ST_PRESSEND:
            begin
                result.event_code = EV_LONG_STOP;
                state_next        = ST_INIT;
                clicks_next       = '0;
                phase_next        = now_ms;
                idle_rep_next     = 1'b0;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            clicks_reg   <= '0;
            phase_reg    <= '0;
            idle_rep_reg <= 1'b0;
            repeat_reg   <= '0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            clicks_reg   <= clicks_next;
            phase_reg    <= phase_next;
            idle_rep_reg <= idle_rep_next;
            repeat_reg   <= repeat_next;
        end
    end

endmodule

// ----- sv/button_click_detector_core.sv -----
// Top level of the button click detector: input register, debouncer, state machine,
// result register. Depends on bcd_pkg, bcd_cfg, bcd_debounce and bcd_fsm.
`timescale 1ns / 1ps

// The detector takes one request per clock cycle while its output is not stalled,
// each a button level sample with a free-running millisecond timestamp, and returns
// exactly one result per request. Each request is first held in the input register;
// when it advances, the level is polarity-corrected, debounced and run through the
// click state machine, and the result is captured in the output register. The
// sustained rate of one request per cycle without output stalls is set by that
// single state update path of a few 32-bit wrapping subtractions and compares. While
// a result waits in the output register, one further request can still be taken
// into the input register, so the input stalls only when both registers are full
// and the output is stalled. Configuration registers are written through a plain
// write port and should only be changed while no request is in flight.
module button_click_detector_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bcd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bcd_pkg::bcd_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bcd_pkg::bcd_result_t         out_data
);
    import bcd_pkg::*;

    bcd_cfg_t    cfg;
    logic        in_valid_reg;
    bcd_item_t   in_item_reg;
    logic        out_valid_reg;
    bcd_result_t out_data_reg;
    logic        advance;
    logic        pressed;
    logic        stable_level;
    bcd_result_t result;

    // The held request moves on whenever the output register is free or is being
    // emptied in this same cycle; block state changes only at that moment.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign pressed  = in_item_reg.level ^ cfg.active_low;

    bcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcd_debounce u_debounce (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .pressed      (pressed),
        .now_ms       (in_item_reg.now_ms),
        .debounce_ms  (cfg.debounce_ms),
        .stable_level (stable_level)
    );

    bcd_fsm u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .stable_level (stable_level),
        .now_ms       (in_item_reg.now_ms),
        .cfg          (cfg),
        .result       (result)
    );

    // Input register: loads on every accepted request and empties as it advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    // Output register: holds a result steady until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/bcd_checker.sv -----
// Port-level checker for the button click detector, bound to the top level.
// Depends on bcd_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_we,
    input logic [bcd_pkg::INDEX_W-1:0]  cfg_index,
    input logic [bcd_pkg::CFG_W-1:0]    cfg_data,
    input logic                         in_valid,
    input logic                         in_stall,
    input bcd_pkg::bcd_item_t           in_data,
    input logic                         out_valid,
    input logic                         out_stall,
    input bcd_pkg::bcd_result_t         out_data
);
    import bcd_pkg::*;

    // A stalled result must stay offered and unchanged.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // With the output free the input side never stalls.
    `ASSERT_IMPLIES(a_no_stall, !out_valid, !in_stall, "input stalled with empty output")

    // A press or long-press start is only reported while the debounced level is pressed.
    `ASSERT_IMPLIES(a_press_level, out_valid && (out_data.event_code == EV_PRESS || out_data.event_code == EV_LONG_START), out_data.debounced_level, "press reported on released level")

    // A single click ends a sequence of exactly one click.
    `ASSERT_IMPLIES(a_click_count, out_valid && out_data.event_code == EV_CLICK, out_data.click_count == 7'd1, "single click with wrong count")

    // A double click ends a sequence of exactly two clicks.
    `ASSERT_IMPLIES(a_double_count, out_valid && out_data.event_code == EV_DOUBLE, out_data.click_count == 7'd2, "double click with wrong count")

endmodule

bind button_click_detector_core bcd_checker u_bcd_checker (.*);

// ----- dv/button_click_detector_checker.sv -----
// Checker for the button click detector: watches the register port, the request and
// result channels, predicts each result and compares it. Depends on bcd_pkg.
`timescale 1ns / 1ps

module button_click_detector_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bcd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  bcd_pkg::bcd_item_t           in_data,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  bcd_pkg::bcd_result_t         out_data,
    output int                           failures,
    output int                           outstanding,
    output int                           compared
);
    import bcd_pkg::*;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_DOWN     = 3'd1,
        PH_UP       = 3'd2,
        PH_COUNT    = 3'd3,
        PH_LONG     = 3'd4,
        PH_LONG_END = 3'd5
    } click_phase_t;

    // Shadow copy of the registers and of the detector state.
    bcd_cfg_t           cfg;
    click_phase_t       phase;
    logic [CLICK_W-1:0] clicks;
    logic [31:0]        phase_start;
    logic               idle_done;
    logic               last_level;
    logic [31:0]        change_time;
    logic               stable;
    logic [31:0]        repeat_time;

    bcd_result_t        predicted_results[$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
        compared    = 0;
    end

    function automatic void close_sequence(input logic [31:0] stamp);
        phase       = PH_INIT;
        clicks      = '0;
        phase_start = stamp;
        idle_done   = 1'b0;
    endfunction

    function automatic bcd_result_t predict_result(input bcd_item_t req);
        bcd_result_t        res;
        logic               pressed;
        logic               deb_neg;
        logic [31:0]        stamp;
        logic [31:0]        deb_mag;
        logic [31:0]        held;
        logic [31:0]        wait_ms;
        logic [CLICK_W-1:0] count;
        res     = '0;
        pressed = req.level ^ cfg.active_low;
        stamp   = req.now_ms;
        deb_neg = cfg.debounce_ms[10];
        deb_mag = deb_neg ? 32'h800 - 32'(cfg.debounce_ms) : 32'(cfg.debounce_ms);

        // A negative debounce time takes a press at once and filters only the release.
        if (pressed && deb_neg)
            stable = 1'b1;
        if (last_level == pressed)
        begin
            held = stamp - change_time;
            if (held >= deb_mag)
                stable = pressed;
        end
        else
        begin
            change_time = stamp;
            last_level  = pressed;
        end

        wait_ms = stamp - phase_start;
        count   = clicks;
        res.event_code = EV_NONE;
        case (phase)
            PH_INIT:
            begin
                if (!idle_done && wait_ms > 32'(cfg.idle_ms) && cfg.idle_enable)
                begin
                    idle_done      = 1'b1;
                    res.idle_event = 1'b1;
                end
                if (stable)
                begin
                    phase          = PH_DOWN;
                    phase_start    = stamp;
                    clicks         = '0;
                    res.event_code = EV_PRESS;
                end
                count = clicks;
            end
            PH_DOWN:
            begin
                if (!stable)
                begin
                    phase       = PH_UP;
                    phase_start = stamp;
                end
                else if (wait_ms > 32'(cfg.press_ms))
                begin
                    res.event_code = EV_LONG_START;
                    phase          = PH_LONG;
                end
            end
            PH_UP:
            begin
                if (clicks < CLICK_SAT)
                    clicks = clicks + 7'd1;
                phase = PH_COUNT;
                count = clicks;
            end
            PH_COUNT:
            begin
                if (stable)
                begin
                    phase       = PH_DOWN;
                    phase_start = stamp;
                end
                else if (wait_ms >= 32'(cfg.click_ms) || clicks == cfg.max_clicks)
                begin
                    if (clicks == 7'd1)
                        res.event_code = EV_CLICK;
                    else if (clicks == 7'd2)
                        res.event_code = EV_DOUBLE;
                    else
                        res.event_code = EV_MULTI;
                    close_sequence(stamp);
                end
            end
            PH_LONG:
            begin
                if (!stable)
                    phase = PH_LONG_END;
                else if (stamp - repeat_time >= 32'(cfg.repeat_interval_ms))
                begin
                    res.event_code = EV_LONG_DURING;
                    repeat_time    = stamp;
                end
            end
            PH_LONG_END:
            begin
                res.event_code = EV_LONG_STOP;
                close_sequence(stamp);
            end
            default:
                phase = PH_INIT;
        endcase

        res.click_count     = count;
        res.debounced_level = stable;
        return res;
    endfunction

    function automatic void flag_field(input string field, input int unsigned want,
                                       input int unsigned got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bcd_result_t want;
        if (!rst_n)
        begin
            cfg.active_low         = 1'b0;
            cfg.debounce_ms        = 11'd50;
            cfg.click_ms           = 16'd400;
            cfg.press_ms           = 16'd800;
            cfg.idle_ms            = 16'd1000;
            cfg.repeat_interval_ms = 16'd0;
            cfg.max_clicks         = 7'd1;
            cfg.idle_enable        = 1'b0;
            phase       = PH_INIT;
            clicks      = '0;
            phase_start = '0;
            idle_done   = 1'b0;
            last_level  = 1'b0;
            change_time = '0;
            stable      = 1'b0;
            repeat_time = '0;
            predicted_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACTIVE_LOW:  cfg.active_low         = cfg_data[0];
                    REG_DEBOUNCE:    cfg.debounce_ms        = cfg_data[10:0];
                    REG_CLICK:       cfg.click_ms           = cfg_data;
                    REG_PRESS:       cfg.press_ms           = cfg_data;
                    REG_IDLE:        cfg.idle_ms            = cfg_data;
                    REG_REPEAT:      cfg.repeat_interval_ms = cfg_data;
                    REG_MAX_CLICKS:  cfg.max_clicks         = cfg_data[CLICK_W-1:0];
                    REG_IDLE_ENABLE: cfg.idle_enable        = cfg_data[0];
                    default: ;
                endcase
            end

            // A result never leaves in the cycle its request is accepted, so retire first.
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result %h arrived with nothing outstanding",
                                 $time, out_data);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compared++;
                    if (out_data.event_code !== want.event_code)
                        flag_field("event_code", want.event_code, out_data.event_code);
                    if (out_data.idle_event !== want.idle_event)
                        flag_field("idle_event", want.idle_event, out_data.idle_event);
                    if (out_data.click_count !== want.click_count)
                        flag_field("click_count", want.click_count, out_data.click_count);
                    if (out_data.debounced_level !== want.debounced_level)
                        flag_field("debounced_level", want.debounced_level,
                                   out_data.debounced_level);
                end
            end

            if (in_valid && !in_stall)
                predicted_results.push_back(predict_result(in_data));

            outstanding <= predicted_results.size();
        end
    end

endmodule

// ----- dv/button_click_detector_core_tb.sv -----
// Top of the button click detector testbench: clock, reset, register writes, request
// stimulus and verdict. Depends on bcd_pkg, the core and button_click_detector_checker.
`timescale 1ns / 1ps

// The stimulus starts with a short scripted run of button samples that walks through
// every event but EV_MULTI, the idle flag with a press, and a timestamp wrap. After that
// it plays randomized button gestures (clicks, double and multi clicks, long presses,
// bouncing contacts, idle stretches, repeated timestamps and raw noise) under a series
// of register settings that include the minimum and maximum of every 16-bit register. One
// scripted burst of fast clicks with no click limit drives the click count into
// saturation. The checker beside the block predicts and compares every result.
module button_click_detector_core_tb;

    import bcd_pkg::*;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = REG_ACTIVE_LOW;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bcd_item_t           in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bcd_result_t         out_data;

    int                  failures;
    int                  outstanding;
    int                  compared;

    // Chance in percent, per cycle, that the sender holds back or the receiver stalls.
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;

    int unsigned         requests_sent    = 0;
    int unsigned         settings_applied = 0;

    // Registers as last written, and the running millisecond timestamp of the samples.
    bcd_cfg_t            settings;
    logic [31:0]         clock_ms = '0;

    button_click_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    button_click_detector_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .failures    (failures),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The result side stalls at random; the rate changes from phase to phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Hard stop in case results stop coming.
    initial
    begin
        #(20_000_000);
        $display("Verification failed");
        $finish;
    end

    // Writes one register. The caller lowers the write enable after its last write,
    // so that back-to-back writes never lower and raise it in the same step.
    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input bcd_cfg_t s);
        write_reg(REG_ACTIVE_LOW,  CFG_W'(s.active_low));
        write_reg(REG_DEBOUNCE,    CFG_W'(s.debounce_ms));
        write_reg(REG_CLICK,       s.click_ms);
        write_reg(REG_PRESS,       s.press_ms);
        write_reg(REG_IDLE,        s.idle_ms);
        write_reg(REG_REPEAT,      s.repeat_interval_ms);
        write_reg(REG_MAX_CLICKS,  CFG_W'(s.max_clicks));
        write_reg(REG_IDLE_ENABLE, CFG_W'(s.idle_enable));
        cfg_we   <= 1'b0;
        settings  = s;
        settings_applied++;
    endtask

    // Holds back new requests until every outstanding result has been taken. The
    // checker's count changes at the edge, so a read there sees the old value.
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Offers one request and waits until it is taken. Idle cycles are inserted
    // before it at the current sender rate.
    task automatic send_request(input bcd_item_t req);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    // Sends a sample of the logical button state, dt milliseconds after the last one.
    // The raw level is inverted when the active-low setting is on.
    task automatic emit(input bit pressed, input int unsigned dt);
        bcd_item_t req;
        clock_ms   = clock_ms + dt;
        req.level  = pressed ^ settings.active_low;
        req.now_ms = clock_ms;
        send_request(req);
    endtask

    task automatic sample_at(input bit pressed, input logic [31:0] stamp);
        clock_ms = stamp;
        emit(pressed, 0);
    endtask

    // Spreads a number of samples of one level over roughly span milliseconds.
    task automatic hold_level(input bit pressed, input int unsigned span,
                              input int unsigned samples);
        for (int unsigned i = 0; i < samples; i++)
            emit(pressed, span / samples + $urandom_range(0, 1));
    endtask

    function automatic logic [15:0] pick_span;
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 50));
            default: return 16'($urandom_range(10, 2000));
        endcase
    endfunction

    // The first two settings put every 16-bit register at its minimum, then at its
    // maximum; later ones mix extremes with ordinary values.
    function automatic bcd_cfg_t random_settings(input int unsigned k);
        bcd_cfg_t s;
        int       deb;
        case ($urandom_range(0, 5))
            0:       deb = -1000;
            1:       deb = -1;
            2:       deb = 0;
            3:       deb = 1000;
            default: deb = int'($urandom_range(0, 2000)) - 1000;
        endcase
        s.active_low         = 1'($urandom_range(0, 1));
        s.debounce_ms        = 11'(deb);
        s.click_ms           = pick_span();
        s.press_ms           = pick_span();
        s.idle_ms            = pick_span();
        s.repeat_interval_ms = pick_span();
        case ($urandom_range(0, 4))
            0:       s.max_clicks = 7'd1;
            1:       s.max_clicks = 7'd2;
            2:       s.max_clicks = 7'd100;
            3:       s.max_clicks = 7'd0;
            default: s.max_clicks = 7'($urandom_range(1, 100));
        endcase
        s.idle_enable = 1'($urandom_range(0, 1));
        if (k == 0)
        begin
            s.active_low         = 1'b0;
            s.debounce_ms        = 11'(-1000);
            s.click_ms           = 16'd0;
            s.press_ms           = 16'd0;
            s.idle_ms            = 16'd0;
            s.repeat_interval_ms = 16'd0;
            s.max_clicks         = 7'd1;
            s.idle_enable        = 1'b0;
        end
        else if (k == 1)
        begin
            s.active_low         = 1'b1;
            s.debounce_ms        = 11'd1000;
            s.click_ms           = 16'hFFFF;
            s.press_ms           = 16'hFFFF;
            s.idle_ms            = 16'hFFFF;
            s.repeat_interval_ms = 16'hFFFF;
            s.max_clicks         = 7'd100;
            s.idle_enable        = 1'b1;
        end
        return s;
    endfunction

    // One randomized gesture. Spans are scaled to the current registers so that most
    // gestures complete real click sequences and long presses; the rest are bounces,
    // idle stretches, repeated timestamps and raw noise.
    task automatic run_gesture;
        int unsigned deb;
        int unsigned n;
        bit          lvl;
        deb = settings.debounce_ms[10] ? 2048 - int'(settings.debounce_ms)
                                       : int'(settings.debounce_ms);
        case ($urandom_range(0, 9))
            0, 1, 2, 9:
            begin
                n = $urandom_range(1, 4);
                for (int unsigned i = 0; i < n; i++)
                begin
                    hold_level(1'b1, deb + 1 + $urandom_range(0, settings.press_ms / 2),
                               $urandom_range(2, 4));
                    hold_level(1'b0, deb + 1 + $urandom_range(0, settings.click_ms / 2),
                               $urandom_range(2, 3));
                end
                hold_level(1'b0, settings.click_ms + deb + 2, 2);
            end
            3, 4:
            begin
                hold_level(1'b1, deb + settings.press_ms + 2 +
                           $urandom_range(0, 3 * settings.repeat_interval_ms + 50),
                           $urandom_range(4, 10));
                hold_level(1'b0, deb + settings.click_ms + 2, 3);
            end
            5:
            begin
                // Contact bounce faster than the debounce time, then a settled level.
                lvl = 1'($urandom_range(0, 1));
                n   = $urandom_range(3, 8);
                for (int unsigned i = 0; i < n; i++)
                    emit(1'($urandom_range(0, 1)), $urandom_range(0, 2));
                hold_level(lvl, deb + 2, 2);
            end
            6:
                hold_level(1'b0, settings.idle_ms + 2 + $urandom_range(0, 100),
                           $urandom_range(2, 4));
            7:
            begin
                n = $urandom_range(2, 5);
                for (int unsigned i = 0; i < n; i++)
                    emit(1'($urandom_range(0, 1)), 0);
            end
            default:
            begin
                // Raw noise: arbitrary levels at arbitrary points in time.
                n = $urandom_range(1, 4);
                for (int unsigned i = 0; i < n; i++)
                    sample_at(1'($urandom_range(0, 1)), $urandom);
            end
        endcase
    endtask

    initial
    begin
        bcd_cfg_t    plan;
        int unsigned block_start;
        int unsigned pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted part: short times so that each event is reached in a few samples.
        plan.active_low         = 1'b0;
        plan.debounce_ms        = 11'd0;
        plan.click_ms           = 16'd10;
        plan.press_ms           = 16'd20;
        plan.idle_ms            = 16'd5;
        plan.repeat_interval_ms = 16'd4;
        plan.max_clicks         = 7'd2;
        plan.idle_enable        = 1'b1;
        apply_settings(plan);

        // Idle flag long after reset, then a single click across the timestamp wrap.
        sample_at(1'b0, 32'hFFFF_FFF8);
        sample_at(1'b1, 32'hFFFF_FFFA);
        sample_at(1'b1, 32'hFFFF_FFFC);
        sample_at(1'b0, 32'hFFFF_FFFF);
        sample_at(1'b0, 32'h0000_0000);
        sample_at(1'b0, 32'd2);
        sample_at(1'b0, 32'd20);
        // Press arriving after the idle time: idle flag and press on one sample.
        sample_at(1'b1, 32'd22);
        sample_at(1'b1, 32'd30);
        // Second click of the pair reaches the click limit and ends as a double.
        sample_at(1'b0, 32'd31);
        sample_at(1'b0, 32'd32);
        sample_at(1'b0, 32'd33);
        sample_at(1'b1, 32'd34);
        sample_at(1'b1, 32'd35);
        sample_at(1'b0, 32'd36);
        sample_at(1'b0, 32'd37);
        sample_at(1'b0, 32'd38);
        sample_at(1'b0, 32'd39);
        // Long press with repeats, held past the repeat spacing, then released.
        sample_at(1'b1, 32'd40);
        sample_at(1'b1, 32'd41);
        sample_at(1'b1, 32'd70);
        sample_at(1'b1, 32'd71);
        sample_at(1'b1, 32'd73);
        sample_at(1'b0, 32'd74);
        sample_at(1'b0, 32'd75);
        sample_at(1'b0, 32'd76);

        // Three idling modes: eager sender with a busy receiver, the reverse, and
        // full speed on both sides. Each mode runs three register settings, and the
        // sender waits for every result before each change of settings.
        pick = 0;
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct  = (mode == 0) ? 10 : (mode == 1) ? 55 : 0;
            recv_stall_pct = (mode == 0) ? 55 : (mode == 1) ? 10 : 0;
            for (int block = 0; block < 3; block++)
            begin
                drain();
                block_start = requests_sent;
                if (mode == 0 && block == 0)
                begin
                    // Fast clicks with no click limit: the count saturates and only
                    // the click gap ends the sequence, as a multi click.
                    plan.active_low         = 1'($urandom_range(0, 1));
                    plan.debounce_ms        = 11'(-1);
                    plan.click_ms           = 16'd400;
                    plan.press_ms           = 16'd800;
                    plan.idle_ms            = 16'd1000;
                    plan.repeat_interval_ms = 16'd0;
                    plan.max_clicks         = 7'd0;
                    plan.idle_enable        = 1'b1;
                    apply_settings(plan);
                    for (int i = 0; i < 130; i++)
                    begin
                        emit(1'b1, 1);
                        emit(1'b0, 1);
                        emit(1'b0, 1);
                    end
                    hold_level(1'b0, 450, 3);
                end
                else
                begin
                    apply_settings(random_settings(pick));
                    pick++;
                end
                while (requests_sent - block_start < 110)
                    run_gesture();
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d requests under %0d register settings, with scripted events,",
                 requests_sent, settings_applied);
        $display("a click-count saturation burst and three idling modes; %0d results checked.",
                 compared);
        if (failures == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
